// ===== rtl/core/lap_pkg.sv =====
// lap_pkg: shared types, constants and helper functions of the phaser block
// no dependencies; imported by the interfaces and every module of the block
package lap_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int SINE_ENTRIES    = 1024;
   localparam int SINE_IDX_W      = 10;
   localparam int DELAY_FRAC_BITS = 8;
   localparam int DELAY_W         = 22;
   localparam int MIX_ONE         = 65536;
   localparam int SAT_W           = 40;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DELAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_DEPTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLPASS_GAIN = 3'd4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_rom_type;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [11:0] base_delay;
      logic [11:0] sweep_depth;
      logic [16:0] wet_mix;
      logic [16:0] allpass_gain;
   } lap_cfg_type;

   function automatic sample_type sat16(input logic signed [SAT_W-1:0] v);
      sample_type r;
      if (v > SAT_W'(32767)) r = 16'sd32767;
      else if (v < -SAT_W'(32768)) r = -16'sd32768;
      else r = SAMPLE_W'(v);
      return r;
   endfunction

   // quarter-wave fold and taylor series to x^9 in q30
   function automatic sample_type sine_entry(input int unsigned idx);
      longint unsigned u;
      longint unsigned r;
      longint unsigned q;
      longint x;
      longint x2;
      longint t;
      longint s;
      longint v;
      u = {32'(idx), 32'd0} / 64'(SINE_ENTRIES);
      q = (u >> 30) & 64'd3;
      r = u & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      x = signed'((r * 64'd1686629713) >> 30);
      x2 = (x * x) >>> 30;
      s = x;
      t = ((x * x2) >>> 30) / 6;
      s = s - t;
      t = ((t * x2) >>> 30) / 20;
      s = s + t;
      t = ((t * x2) >>> 30) / 42;
      s = s - t;
      t = ((t * x2) >>> 30) / 72;
      s = s + t;
      if (s < 0) s = 0;
      v = (s + 16384) >>> 15;
      if (v > 32767) v = 32767;
      if (q >= 64'd2) v = -v;
      return SAMPLE_W'(v);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         rom[i] = sine_entry(i);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/core/lap_if.sv =====
// lap_if: valid/ready channel interfaces of the phaser block (samples and csr writes)
// depends on lap_pkg
interface lap_req_if import lap_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface lap_rsp_if import lap_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

interface lap_csr_if import lap_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lap_front.sv =====
// lap_front: accepts samples, steps the lfo, looks up the sine rom and works out
// the ring read position; depends on lap_pkg and lap_if
module lap_front import lap_pkg::*; #(
   parameter int RING_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  lap_cfg_type cfg,
   input  logic        clear_busy,
   lap_req_if.sink     req_if,
   input  logic        q_full,
   output logic        push,
   output logic [SAMPLE_W+DELAY_FRAC_BITS+3*$clog2(RING_DEPTH)-1:0] push_data
);
   localparam int RW    = $clog2(RING_DEPTH);
   localparam int LW    = ($clog2(RING_DEPTH + 1) < 13) ? $clog2(RING_DEPTH + 1) : 13;
   localparam int TW    = LW + DELAY_FRAC_BITS;
   localparam int XW    = (RW + 1 > LW) ? RW + 1 : LW;
   localparam int F     = DELAY_FRAC_BITS;
   localparam sine_rom_type SINE_ROM = build_sine_rom();

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_ROM  = 3'd1;
   localparam logic [2:0] F_DLY  = 3'd2;
   localparam logic [2:0] F_MOD  = 3'd3;
   localparam logic [2:0] F_POS  = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [31:0]         phase_ff;
   logic [RW-1:0]       widx_ff;
   sample_type          dry_ff;
   sample_type          sv_ff;
   logic [LW-1:0]       ring_len_ff;
   logic [DELAY_W-1:0]  rem_ff;
   logic [4:0]          k_ff;
   logic [$bits(push_data)-1:0] cmd_ff;

   logic [12:0]         len_sum;
   logic [LW-1:0]       ring_len_in;
   logic [TW-1:0]       total;
   logic [DELAY_W-1:0]  tot_ext;
   logic [15:0]         u_val;
   logic [27:0]         sweep_prod;
   logic [DELAY_W-1:0]  delay_in;
   logic [DELAY_W-1:0]  rem_a, rem_b;
   logic [4:0]          k_lo;
   logic [TW:0]         pos;
   logic [RW-1:0]       i0, i1;
   logic [XW-1:0]       i0_inc, w_inc;
   logic [RW-1:0]       widx_next;

   assign req_if.ready = (state_ff == F_IDLE) && !clear_busy;
   assign push         = (state_ff == F_PUSH) && !q_full;
   assign push_data    = cmd_ff;

   always_comb begin
      len_sum = 13'(cfg.base_delay) + 13'(cfg.sweep_depth);
      if (len_sum == 13'd0) ring_len_in = LW'(1);
      else if (int'(len_sum) > RING_DEPTH) ring_len_in = LW'(RING_DEPTH);
      else ring_len_in = LW'(len_sum);
   end

   assign total      = {ring_len_ff, {F{1'b0}}};
   assign tot_ext    = DELAY_W'(total);
   // s + 32768 is the sine word with its sign bit flipped
   assign u_val      = {~sv_ff[15], sv_ff[14:0]};
   assign sweep_prod = u_val * cfg.sweep_depth;
   assign delay_in   = DELAY_W'({cfg.base_delay, {F{1'b0}}}) + DELAY_W'(sweep_prod >> (16 - F));

   // two restoring remainder steps per cycle
   assign k_lo = k_ff - 5'd1;
   always_comb begin
      rem_a = rem_ff;
      if ((rem_a >> k_ff) >= tot_ext) rem_a = rem_a - (tot_ext << k_ff);
      rem_b = rem_a;
      if ((rem_b >> k_lo) >= tot_ext) rem_b = rem_b - (tot_ext << k_lo);
   end

   always_comb begin
      pos = (TW + 1)'({widx_ff, {F{1'b0}}}) + (TW + 1)'(total) - (TW + 1)'(rem_ff);
      if (pos >= (TW + 1)'(total)) pos = pos - (TW + 1)'(total);
      i0 = RW'(pos >> F);
      i0_inc = XW'(i0) + XW'(1);
      if (i0_inc >= XW'(ring_len_ff)) i1 = '0;
      else i1 = RW'(i0_inc);
      w_inc = XW'(widx_ff) + XW'(1);
      if (w_inc >= XW'(ring_len_ff)) widx_next = '0;
      else widx_next = RW'(w_inc);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_if.valid && req_if.ready) state_in = F_ROM;
         F_ROM:   state_in = F_DLY;
         F_DLY:   state_in = F_MOD;
         F_MOD:   if (k_ff == 5'd1) state_in = F_POS;
         F_POS:   state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= '0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            F_IDLE: begin
               if (req_if.valid && req_if.ready) begin
                  phase_ff <= phase_ff + cfg.phase_step;
                  dry_ff   <= req_if.sample_in;
               end
            end
            F_ROM: begin
               sv_ff       <= SINE_ROM[phase_ff[31 -: SINE_IDX_W]];
               ring_len_ff <= ring_len_in;
            end
            F_DLY: begin
               rem_ff <= delay_in;
               k_ff   <= 5'(DELAY_W - 1);
               if (XW'(widx_ff) >= XW'(ring_len_ff)) widx_ff <= '0;
            end
            F_MOD: begin
               rem_ff <= rem_b;
               k_ff   <= k_ff - 5'd2;
            end
            F_POS: begin
               cmd_ff  <= {dry_ff, pos[F-1:0], i0, i1, widx_ff};
               widx_ff <= widx_next;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/lap_queue.sv =====
// lap_queue: two-entry fifo of read commands between front and back
// depends on lap_pkg for style only
module lap_queue import lap_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== rtl/core/lap_back.sv =====
// lap_back: runs the all-pass stage chain over the ring memory and the wet/dry mix
// depends on lap_pkg and lap_if
module lap_back import lap_pkg::*; #(
   parameter int STAGES     = 4,
   parameter int RING_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  lap_cfg_type cfg,
   output logic        clear_busy,
   input  logic        q_valid,
   input  logic [SAMPLE_W+DELAY_FRAC_BITS+3*$clog2(RING_DEPTH)-1:0] q_data,
   output logic        pop,
   lap_rsp_if.source   rsp_if
);
   localparam int RW       = $clog2(RING_DEPTH);
   localparam int F        = DELAY_FRAC_BITS;
   localparam int DEPTH_ALL = STAGES * RING_DEPTH;
   localparam int AW       = $clog2(DEPTH_ALL);
   localparam int SW       = (STAGES > 1) ? $clog2(STAGES) : 1;

   localparam logic [2:0] B_CLR  = 3'd0;
   localparam logic [2:0] B_IDLE = 3'd1;
   localparam logic [2:0] B_RD   = 3'd2;
   localparam logic [2:0] B_D    = 3'd3;
   localparam logic [2:0] B_Y    = 3'd4;
   localparam logic [2:0] B_W    = 3'd5;
   localparam logic [2:0] B_MIX  = 3'd6;
   localparam logic [2:0] B_OUT  = 3'd7;

   sample_type         ring_mem [DEPTH_ALL];
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff;
   logic [SW-1:0]      stage_ff;
   logic [$bits(q_data)-1:0] cmd_ff;
   sample_type         x_ff, d_ff, y_ff, rd0_ff, rd1_ff;
   logic signed [33:0] pa_ff, pb_ff;
   logic               out_valid_ff;
   sample_type         out_data_ff;

   sample_type         c_dry;
   logic [F-1:0]       c_frac;
   logic [RW-1:0]      c_i0, c_i1, c_widx;
   logic [AW-1:0]      stage_base, ra0, ra1, wa;
   logic               we;
   sample_type         wd;
   logic signed [26:0] dsum;
   logic signed [33:0] gprod;
   logic signed [34:0] mix_sum;
   logic               out_free;

   assign {c_dry, c_frac, c_i0, c_i1, c_widx} = cmd_ff;
   assign stage_base = AW'(int'(stage_ff) * RING_DEPTH);
   assign ra0 = stage_base + AW'(c_i0);
   assign ra1 = stage_base + AW'(c_i1);
   assign we  = (state_ff == B_CLR) || (state_ff == B_W);
   assign wa  = (state_ff == B_CLR) ? clr_ff : stage_base + AW'(c_widx);

   assign dsum = $signed({1'b0, (F + 1)'(2 ** F) - (F + 1)'(c_frac)}) * rd0_ff
               + $signed({1'b0, c_frac}) * rd1_ff;
   assign gprod = y_ff * $signed({1'b0, cfg.allpass_gain});
   always_comb begin
      if (state_ff == B_CLR) wd = '0;
      else wd = sat16(SAT_W'(x_ff) + SAT_W'(gprod >>> 16));
   end
   assign mix_sum = 35'(pa_ff) + 35'(pb_ff);

   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign clear_busy    = (state_ff == B_CLR);
   assign pop           = (state_ff == B_IDLE) && q_valid;
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.sample_out = out_data_ff;

   always_ff @(posedge clock) begin
      if (we) ring_mem[wa] <= wd;
      rd0_ff <= ring_mem[ra0];
      rd1_ff <= ring_mem[ra1];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLR:   if (clr_ff == AW'(DEPTH_ALL - 1)) state_in = B_IDLE;
         B_IDLE:  if (q_valid) state_in = B_RD;
         B_RD:    state_in = B_D;
         B_D:     state_in = B_Y;
         B_Y:     state_in = B_W;
         B_W:     state_in = (stage_ff == SW'(STAGES - 1)) ? B_MIX : B_RD;
         B_MIX:   state_in = B_OUT;
         B_OUT:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         clr_ff       <= '0;
         stage_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_OUT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_if.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            B_CLR: clr_ff <= clr_ff + AW'(1);
            B_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_data;
                  x_ff     <= q_data[$bits(q_data)-1 -: SAMPLE_W];
                  stage_ff <= '0;
               end
            end
            B_D: d_ff <= SAMPLE_W'(dsum >>> F);
            B_Y: y_ff <= sat16(SAT_W'(d_ff) - SAT_W'(x_ff));
            B_W: begin
               x_ff <= y_ff;
               if (stage_ff != SW'(STAGES - 1)) stage_ff <= stage_ff + SW'(1);
            end
            B_MIX: begin
               pa_ff <= $signed({1'b0, cfg.wet_mix}) * x_ff;
               pb_ff <= $signed({1'b0, 17'(MIX_ONE - int'(cfg.wet_mix))}) * c_dry;
            end
            B_OUT: begin
               if (out_free) out_data_ff <= sat16(SAT_W'(mix_sum >>> 16));
            end
            default: begin
            end
         endcase
      end
   end

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLR) |-> !out_valid_ff)
      else $error("result valid during ring clear");
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (stage_ff <= SW'(STAGES - 1)))
      else $error("stage counter out of range");
   a_mix_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && out_free) |=> out_valid_ff)
      else $error("mixed result not registered");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == B_RD))
      else $error("popped command not started");

endmodule

// ===== rtl/core/lfo_allpass_phaser.sv =====
// lfo_allpass_phaser: lfo-swept all-pass phaser, front computes read positions,
// back runs STAGES stages over one ring memory; each stage takes the back through its
// read/interpolate/saturate/write step, and the front may accept the next sample while
// the back is still working on the last one.
// reset: synchronous; a clearing pass zeroes all STAGES*RING_DEPTH ring words (16384 by
// default), during which no sample is accepted; csr writes are always taken.
module lfo_allpass_phaser import lap_pkg::*; #(
   parameter int STAGES     = 4,
   parameter int RING_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   lap_req_if.sink     req_if,
   lap_rsp_if.source   rsp_if,
   lap_csr_if.sink     csr_if
);
   localparam int CMD_W = SAMPLE_W + DELAY_FRAC_BITS + 3 * $clog2(RING_DEPTH);

   logic [31:0] phase_step_ff;
   logic [11:0] base_delay_ff;
   logic [11:0] sweep_depth_ff;
   logic [16:0] wet_mix_ff;
   logic [16:0] allpass_gain_ff;
   lap_cfg_type cfg;
   logic        clear_busy, q_full, q_valid, push, pop;
   logic [CMD_W-1:0] push_data, q_data;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= 32'd89478;
         base_delay_ff   <= 12'd144;
         sweep_depth_ff  <= 12'd2400;
         wet_mix_ff      <= 17'd58982;
         allpass_gain_ff <= 17'd32768;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_PHASE_STEP:   phase_step_ff   <= csr_if.data;
            CSR_BASE_DELAY:   base_delay_ff   <= csr_if.data[11:0];
            CSR_SWEEP_DEPTH:  sweep_depth_ff  <= csr_if.data[11:0];
            CSR_WET_MIX:      wet_mix_ff      <= csr_if.data[16:0];
            CSR_ALLPASS_GAIN: allpass_gain_ff <= csr_if.data[16:0];
            default: begin
            end
         endcase
      end
   end

   // gain and wet above unity act as unity
   always_comb begin
      cfg.phase_step   = phase_step_ff;
      cfg.base_delay   = base_delay_ff;
      cfg.sweep_depth  = sweep_depth_ff;
      cfg.wet_mix      = (int'(wet_mix_ff) > MIX_ONE) ? 17'(MIX_ONE) : wet_mix_ff;
      cfg.allpass_gain = (int'(allpass_gain_ff) > MIX_ONE) ? 17'(MIX_ONE) : allpass_gain_ff;
   end

   lap_front #(.RING_DEPTH(RING_DEPTH)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg), .clear_busy(clear_busy),
      .req_if(req_if), .q_full(q_full), .push(push), .push_data(push_data)
   );

   lap_queue #(.WIDTH(CMD_W)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(q_full),
      .pop(pop), .not_empty(q_valid), .pop_data(q_data)
   );

   lap_back #(.STAGES(STAGES), .RING_DEPTH(RING_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .clear_busy(clear_busy),
      .q_valid(q_valid), .q_data(q_data), .pop(pop), .rsp_if(rsp_if)
   );

endmodule
